// ----- design/stereo_frame_ring_drop_oldest_unit_assert.svh -----
// ----------------------------------------------------------------------------
// stereo frame ring assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef STEREO_FRAME_RING_DROP_OLDEST_UNIT_ASSERT_SVH
`define STEREO_FRAME_RING_DROP_OLDEST_UNIT_ASSERT_SVH

// same-cycle implication
`define SFR_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in stereo frame ring");

// next-cycle implication
`define SFR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in stereo frame ring");

`endif

// ----- design/sfr_pkg.sv -----
// ----------------------------------------------------------------------------
// sfr_pkg
// shared types and constants of the stereo frame ring
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfr_pkg;

    localparam int CAPACITY_FRAMES_DEF = 1024;
    localparam int MODE_W   = 2;
    localparam int SAMPLE_W = 16;
    localparam int FRAME_W  = 2 * SAMPLE_W;
    localparam int SEQ_W    = 48;
    localparam int STATUS_W = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_WRITE = 2'd0,
        MODE_READ  = 2'd1,
        MODE_CLEAR = 2'd2
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_WRITTEN      = 3'd0,
        ST_WRITTEN_DROP = 3'd1,
        ST_READ_OK      = 3'd2,
        ST_READ_EMPTY   = 3'd3,
        ST_CLEARED      = 3'd4,
        ST_IGNORED      = 3'd5
    } status_t;

    // per-transaction result info, count travels beside it
    typedef struct packed {
        status_t            status;
        logic [SEQ_W-1:0]   seq;
    } result_info_t;

endpackage

// ----- design/sfr_frame_mem.sv -----
// ----------------------------------------------------------------------------
// sfr_frame_mem
// frame store, one write port and one read port, registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfr_frame_mem #(
    parameter int DEPTH = sfr_pkg::CAPACITY_FRAMES_DEF
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [$clog2(DEPTH)-1:0]      wr_addr,
    input  logic [sfr_pkg::FRAME_W-1:0]   wr_data,
    input  logic                          rd_en,
    input  logic [$clog2(DEPTH)-1:0]      rd_addr,
    output logic [sfr_pkg::FRAME_W-1:0]   rd_data
);

    logic [sfr_pkg::FRAME_W-1:0] mem [DEPTH];
    logic [sfr_pkg::FRAME_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/sfr_ctrl.sv -----
// ----------------------------------------------------------------------------
// sfr_ctrl
// queue pointer, count and oldest sequence, with frame store access control
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfr_ctrl #(
    parameter int CAPACITY_FRAMES = sfr_pkg::CAPACITY_FRAMES_DEF,
    localparam int PW = $clog2(CAPACITY_FRAMES),
    localparam int CW = $clog2(CAPACITY_FRAMES + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic [sfr_pkg::MODE_W-1:0]      mode,
    input  logic [sfr_pkg::SAMPLE_W-1:0]    left_sample,
    input  logic [sfr_pkg::SAMPLE_W-1:0]    right_sample,
    input  logic [sfr_pkg::SEQ_W-1:0]       frame_sequence,
    output logic                            mem_wr_en,
    output logic [PW-1:0]                   mem_wr_addr,
    output logic [sfr_pkg::FRAME_W-1:0]     mem_wr_data,
    output logic                            mem_rd_en,
    output logic [PW-1:0]                   mem_rd_addr,
    output sfr_pkg::result_info_t           info_next,
    output logic [CW-1:0]                   count_out
);

    localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY_FRAMES);
    localparam logic [PW:0]   CAP_SUM   = (PW + 1)'(CAPACITY_FRAMES);
    localparam logic [PW-1:0] LAST_PTR  = PW'(CAPACITY_FRAMES - 1);

    logic [PW-1:0]               rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]               count_reg, count_next;
    logic [sfr_pkg::SEQ_W-1:0]   seq_reg, seq_next;

    logic [PW-1:0]               ptr_inc;
    logic [sfr_pkg::SEQ_W-1:0]   seq_inc;
    logic [PW:0]                 slot_sum, slot_wrap;
    logic                        full, empty;
    logic                        wr_req, rd_req;
    sfr_pkg::status_t            status;

    assign ptr_inc   = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
    assign seq_inc   = seq_reg + 1'b1;
    assign slot_sum  = {1'b0, rd_ptr_reg} + (PW + 1)'(count_reg);
    assign slot_wrap = (slot_sum >= CAP_SUM) ? slot_sum - CAP_SUM : slot_sum;
    assign full      = (count_reg == CAP_COUNT);
    assign empty     = (count_reg == '0);

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        seq_next    = seq_reg;
        wr_req      = 1'b0;
        rd_req      = 1'b0;
        mem_wr_addr = slot_wrap[PW-1:0];
        status      = sfr_pkg::ST_IGNORED;
        unique case (sfr_pkg::mode_t'(mode))
            sfr_pkg::MODE_WRITE:
            begin
                wr_req = 1'b1;
                if (full)
                begin
                    // oldest slot is reused for the new frame
                    mem_wr_addr = rd_ptr_reg;
                    rd_ptr_next = ptr_inc;
                    seq_next    = seq_inc;
                    status      = sfr_pkg::ST_WRITTEN_DROP;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    if (empty)
                    begin
                        seq_next = frame_sequence;
                    end
                    status = sfr_pkg::ST_WRITTEN;
                end
            end
            sfr_pkg::MODE_READ:
            begin
                if (empty)
                begin
                    status = sfr_pkg::ST_READ_EMPTY;
                end
                else
                begin
                    rd_req      = 1'b1;
                    count_next  = count_reg - 1'b1;
                    seq_next    = seq_inc;
                    rd_ptr_next = (count_reg == CW'(1)) ? '0 : ptr_inc;
                    status      = sfr_pkg::ST_READ_OK;
                end
            end
            sfr_pkg::MODE_CLEAR:
            begin
                rd_ptr_next = '0;
                count_next  = '0;
                seq_next    = '0;
                status      = sfr_pkg::ST_CLEARED;
            end
            default:
            begin
                status = sfr_pkg::ST_IGNORED;
            end
        endcase
    end

    assign mem_wr_en   = accept && wr_req;
    assign mem_rd_en   = accept && rd_req;
    assign mem_rd_addr = rd_ptr_reg;
    assign mem_wr_data = {right_sample, left_sample};

    assign info_next.status = status;
    assign info_next.seq    = seq_next;
    assign count_out        = count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            seq_reg    <= '0;
        end
        else if (accept)
        begin
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            seq_reg    <= seq_next;
        end
    end

endmodule

// ----- design/stereo_frame_ring_drop_oldest_unit.sv -----
// ----------------------------------------------------------------------------
// stereo_frame_ring_drop_oldest_unit
// ring queue of stereo frames that drops its oldest frame when full
// ----------------------------------------------------------------------------
//
//   channel  handshake                    payload
//   -------  ---------------------------  -----------------------------------
//   item     item_valid / item_stall      mode, left_sample, right_sample,
//                                         frame_sequence, last_in_batch
//   result   result_valid / result_stall  packed_frame, status,
//                                         frames_queued, oldest_sequence
//
// one transaction per cycle sustained while result_stall is low; a result goes
// from the lookup stage, which waits on the store read, to the output register
// reset clears pointer, count and oldest sequence at once, no clearing pass;
// the frame store itself is not reset
// a stalled result holds the output register; the lookup stage then holds too
// and item_stall rises until the output moves
//
`timescale 1ns / 1ps
`include "stereo_frame_ring_drop_oldest_unit_assert.svh"

module stereo_frame_ring_drop_oldest_unit #(
    parameter int CAPACITY_FRAMES = sfr_pkg::CAPACITY_FRAMES_DEF,
    localparam int PW = $clog2(CAPACITY_FRAMES),
    localparam int CW = $clog2(CAPACITY_FRAMES + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  logic [sfr_pkg::MODE_W-1:0]      mode,
    input  logic signed [sfr_pkg::SAMPLE_W-1:0] left_sample,
    input  logic signed [sfr_pkg::SAMPLE_W-1:0] right_sample,
    input  logic [sfr_pkg::SEQ_W-1:0]       frame_sequence,
    input  logic                            last_in_batch,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [sfr_pkg::FRAME_W-1:0]     packed_frame,
    output logic [sfr_pkg::STATUS_W-1:0]    status,
    output logic [CW-1:0]                   frames_queued,
    output logic [sfr_pkg::SEQ_W-1:0]       oldest_sequence
);

    // last_in_batch only marks burst boundaries, queue state ignores it

    logic                           item_accept;
    logic                           a_move;
    logic                           out_take;

    // store access from the control block
    logic                           mem_wr_en;
    logic [PW-1:0]                  mem_wr_addr;
    logic [sfr_pkg::FRAME_W-1:0]    mem_wr_data;
    logic                           mem_rd_en;
    logic [PW-1:0]                  mem_rd_addr;
    logic [sfr_pkg::FRAME_W-1:0]    mem_rd_data;

    sfr_pkg::result_info_t          info_next;
    logic [CW-1:0]                  count_next;

    // lookup stage: waits on the store read
    logic                           a_valid_reg;
    sfr_pkg::result_info_t          a_info_reg;
    logic [CW-1:0]                  a_count_reg;

    // output register
    logic                           result_valid_reg;
    logic [sfr_pkg::FRAME_W-1:0]    packed_frame_reg;
    sfr_pkg::result_info_t          out_info_reg;
    logic [CW-1:0]                  out_count_reg;

    // handshake: the lookup stage moves on whenever the output is free or taken
    assign out_take    = result_valid_reg && !result_stall;
    assign a_move      = a_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall  = a_valid_reg && !a_move;
    assign item_accept = item_valid && !item_stall;

    sfr_ctrl #(
        .CAPACITY_FRAMES (CAPACITY_FRAMES)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (item_accept),
        .mode           (mode),
        .left_sample    (left_sample),
        .right_sample   (right_sample),
        .frame_sequence (frame_sequence),
        .mem_wr_en      (mem_wr_en),
        .mem_wr_addr    (mem_wr_addr),
        .mem_wr_data    (mem_wr_data),
        .mem_rd_en      (mem_rd_en),
        .mem_rd_addr    (mem_rd_addr),
        .info_next      (info_next),
        .count_out      (count_next)
    );

    // a write lands at its accept edge, so a following read never sees stale data
    sfr_frame_mem #(
        .DEPTH (CAPACITY_FRAMES)
    ) u_frame_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_accept)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (a_move)
            begin
                a_valid_reg <= 1'b0;
            end

            if (a_move)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            a_info_reg  <= info_next;
            a_count_reg <= count_next;
        end
        if (a_move)
        begin
            // frame data only for a successful read
            packed_frame_reg <= (a_info_reg.status == sfr_pkg::ST_READ_OK)
                                ? mem_rd_data : '0;
            out_info_reg     <= a_info_reg;
            out_count_reg    <= a_count_reg;
        end
    end

    assign result_valid    = result_valid_reg;
    assign packed_frame    = packed_frame_reg;
    assign status          = out_info_reg.status;
    assign frames_queued   = out_count_reg;
    assign oldest_sequence = out_info_reg.seq;

    // count never goes past capacity
    `SFR_ASSERT_IMPL(a_count_bound, result_valid, frames_queued <= CW'(CAPACITY_FRAMES))
    // only a successful read carries frame data
    `SFR_ASSERT_IMPL(a_frame_zero, result_valid && (status != sfr_pkg::ST_READ_OK),
                     packed_frame == '0)
    // empty read and clear both leave an empty queue
    `SFR_ASSERT_IMPL(a_empty_status,
                     result_valid && ((status == sfr_pkg::ST_READ_EMPTY)
                                      || (status == sfr_pkg::ST_CLEARED)),
                     frames_queued == '0)
    // a drop only happens with the queue full
    `SFR_ASSERT_IMPL(a_drop_full, result_valid && (status == sfr_pkg::ST_WRITTEN_DROP),
                     frames_queued == CW'(CAPACITY_FRAMES))
    // an item accepted now is held in the lookup stage in the next cycle
    `SFR_ASSERT_NEXT(a_stage_fill, item_accept, a_valid_reg)

endmodule

// ----- dv/stereo_frame_ring_drop_oldest_unit_tb.sv -----
// ----------------------------------------------------------------------------
// stereo_frame_ring_drop_oldest_unit_tb
// self-checking bench for the overwriting stereo frame ring; a scoreboard
// tracks its own copy of the ring and checks every result transaction in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stereo_frame_ring_drop_oldest_unit_tb;

    import sfr_pkg::*;

    localparam int CAP           = CAPACITY_FRAMES_DEF;
    localparam int COUNT_W       = $clog2(CAP + 1);
    localparam int RANDOM_ITEMS  = 900;
    // last stretch of the run goes without any idling on either side
    localparam int NO_IDLE_AFTER = 780;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 8;

    // mode code outside the three operations; the block answers it as ignored
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // one expected result transaction
    typedef struct {
        logic [FRAME_W-1:0] frame;
        status_t            status;
        logic [COUNT_W-1:0] count;
        logic [SEQ_W-1:0]   seq;
    } ring_result_t;

    // ------------------------------------------------------------------------
    // scoreboard: private copy of the ring plus the queue of pending results
    // ------------------------------------------------------------------------
    class frame_ring_scoreboard;
        logic [FRAME_W-1:0] frame_store [CAP];
        int unsigned        read_ptr;
        int unsigned        frame_count;
        logic [SEQ_W-1:0]   first_seq;
        ring_result_t       pending_results [$];
        int                 mismatches;

        function new();
            read_ptr    = 0;
            frame_count = 0;
            first_seq   = '0;
            mismatches  = 0;
        endfunction

        // apply one accepted operation to the ring copy, queue its result
        function void note_item(input logic [MODE_W-1:0] m,
                                input logic [SAMPLE_W-1:0] l,
                                input logic [SAMPLE_W-1:0] r,
                                input logic [SEQ_W-1:0] s);
            ring_result_t exp_r;
            int unsigned  slot;
            exp_r.frame  = '0;
            exp_r.status = ST_IGNORED;
            case (m)
                MODE_WRITE:
                begin
                    exp_r.status = ST_WRITTEN;
                    if (frame_count == 0)
                        first_seq = s;
                    if (frame_count >= CAP)
                    begin
                        // full: oldest frame falls out
                        read_ptr     = (read_ptr + 1) % CAP;
                        frame_count  = CAP - 1;
                        first_seq    = first_seq + 1'b1;
                        exp_r.status = ST_WRITTEN_DROP;
                    end
                    slot = (read_ptr + frame_count) % CAP;
                    frame_store[slot] = {r, l};
                    frame_count++;
                end
                MODE_READ:
                begin
                    if (frame_count == 0)
                        exp_r.status = ST_READ_EMPTY;
                    else
                    begin
                        exp_r.status = ST_READ_OK;
                        exp_r.frame  = frame_store[read_ptr];
                        read_ptr     = (read_ptr + 1) % CAP;
                        frame_count--;
                        first_seq    = first_seq + 1'b1;
                        if (frame_count == 0)
                            read_ptr = 0;
                    end
                end
                MODE_CLEAR:
                begin
                    read_ptr     = 0;
                    frame_count  = 0;
                    first_seq    = '0;
                    exp_r.status = ST_CLEARED;
                end
                default:
                    exp_r.status = ST_IGNORED;
            endcase
            exp_r.count = COUNT_W'(frame_count);
            exp_r.seq   = first_seq;
            pending_results.push_back(exp_r);
        endfunction

        function void check_result(input logic [FRAME_W-1:0] pf,
                                   input logic [STATUS_W-1:0] st,
                                   input logic [COUNT_W-1:0] fq,
                                   input logic [SEQ_W-1:0] os);
            ring_result_t exp_r;
            if (pending_results.size() == 0)
            begin
                $error("result transaction with none outstanding: status %0d", st);
                mismatches++;
                return;
            end
            exp_r = pending_results.pop_front();
            if (pf !== exp_r.frame)
            begin
                $error("packed_frame: expected %h, actual %h", exp_r.frame, pf);
                mismatches++;
            end
            if (st !== exp_r.status)
            begin
                $error("status: expected %0d, actual %0d", exp_r.status, st);
                mismatches++;
            end
            if (fq !== exp_r.count)
            begin
                $error("frames_queued: expected %0d, actual %0d", exp_r.count, fq);
                mismatches++;
            end
            if (os !== exp_r.seq)
            begin
                $error("oldest_sequence: expected %h, actual %h", exp_r.seq, os);
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // block ports
    // ------------------------------------------------------------------------
    logic                 clk;
    logic                 rst_n;
    logic                 item_valid;
    logic                 item_stall;
    logic [MODE_W-1:0]    mode;
    logic [SAMPLE_W-1:0]  left_sample;
    logic [SAMPLE_W-1:0]  right_sample;
    logic [SEQ_W-1:0]     frame_sequence;
    logic                 last_in_batch;
    logic                 result_valid;
    logic                 result_stall;
    logic [FRAME_W-1:0]   packed_frame;
    logic [STATUS_W-1:0]  status;
    logic [COUNT_W-1:0]   frames_queued;
    logic [SEQ_W-1:0]     oldest_sequence;

    frame_ring_scoreboard ring_sb;

    bit no_idle;        // set for the closing stretch, kills all gaps and stalls
    int ring_items;     // random transactions issued so far
    int fills_done;
    int cycle_count;
    int stall_left;
    int free_left;

    stereo_frame_ring_drop_oldest_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .mode            (mode),
        .left_sample     (left_sample),
        .right_sample    (right_sample),
        .frame_sequence  (frame_sequence),
        .last_in_batch   (last_in_batch),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .packed_frame    (packed_frame),
        .status          (status),
        .frames_queued   (frames_queued),
        .oldest_sequence (oldest_sequence)
    );

    // 20 ns clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // result side back-pressure: stall bursts of random length between free
    // runs, now and then a long free stretch
    always @(posedge clk)
    begin
        if (!rst_n || no_idle)
            result_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            result_stall <= 1'b1;
        end
        else if (free_left > 0)
        begin
            free_left--;
            result_stall <= 1'b0;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            stall_left = $urandom_range(0, 12);
            result_stall <= 1'b1;
        end
        else
        begin
            free_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(0, 30);
            result_stall <= 1'b0;
        end
    end

    // every result transaction goes to the scoreboard; values seen here are
    // the ones that stood before this edge
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            ring_sb.check_result(packed_frame, status, frames_queued, oldest_sequence);
    end

    function automatic logic [SEQ_W-1:0] rand48();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[SEQ_W-1:0];
    endfunction

    // drive one item transaction and hold it until accepted; an occasional
    // idle gap goes in front of it
    task automatic send_item(input logic [MODE_W-1:0] m,
                             input logic [SAMPLE_W-1:0] l,
                             input logic [SAMPLE_W-1:0] r,
                             input logic [SEQ_W-1:0] s,
                             input logic last);
        if (!no_idle && $urandom_range(0, 5) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        item_valid     <= 1'b1;
        mode           <= m;
        left_sample    <= l;
        right_sample   <= r;
        frame_sequence <= s;
        last_in_batch  <= last;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        ring_sb.note_item(m, l, r, s);
    endtask

    // a well-formed write burst: consecutive sequence numbers, last flagged;
    // a quarter of the bursts start just below the sequence wrap
    task automatic write_burst(input int n);
        logic [SEQ_W-1:0] base;
        int               i;
        base = ($urandom_range(0, 3) == 0) ? {SEQ_W{1'b1}} - SEQ_W'($urandom_range(0, 40))
                                             : rand48();
        for (i = 0; i < n; i++)
            send_item(MODE_WRITE, 16'($urandom), 16'($urandom), base + SEQ_W'(i), i == n - 1);
    endtask

    // reads carry junk in the unused fields
    task automatic read_burst(input int n);
        int i;
        for (i = 0; i < n; i++)
            send_item(MODE_READ, 16'($urandom), 16'($urandom), rand48(), 1'($urandom));
    endtask

    // unstructured traffic, the unused mode code now and then
    task automatic noise_burst(input int n);
        logic [MODE_W-1:0] m;
        int                i;
        for (i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 19))
                0:       m = MODE_UNUSED;
                1:       m = MODE_CLEAR;
                default: m = ($urandom_range(0, 1) == 0) ? MODE_WRITE : MODE_READ;
            endcase
            send_item(m, 16'($urandom), 16'($urandom), rand48(), 1'($urandom));
        end
    endtask

    // push the ring past full so that writes start dropping the oldest frame
    task automatic overrun_fill();
        int left_to_write;
        int n;
        left_to_write = CAP - int'(ring_sb.frame_count) + $urandom_range(1, 60);
        while (left_to_write > 0)
        begin
            n = $urandom_range(1, 40);
            if (n > left_to_write)
                n = left_to_write;
            write_burst(n);
            left_to_write -= n;
        end
    endtask

    initial
    begin
        int n;
        ring_sb        = new();
        no_idle        = 1'b0;
        ring_items     = 0;
        fills_done     = 0;
        cycle_count    = 0;
        stall_left     = 0;
        free_left      = 0;
        rst_n          = 1'b0;
        item_valid     = 1'b0;
        mode           = MODE_WRITE;
        left_sample    = '0;
        right_sample   = '0;
        frame_sequence = '0;
        last_in_batch  = 1'b0;
        result_stall   = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---------------- directed part ----------------
        // read of an empty ring straight after reset
        send_item(MODE_READ, 16'h0000, 16'h0000, '0, 1'b0);
        // sample extremes; first write starts the sequence just below wrap,
        // later writes to a non-empty ring must not take their sequence
        send_item(MODE_WRITE, 16'h8000, 16'h7fff, 48'hffff_ffff_fffe, 1'b0);
        send_item(MODE_WRITE, 16'h7fff, 16'h8000, 48'h0000_0000_0000, 1'b0);
        send_item(MODE_WRITE, 16'hffff, 16'h0000, 48'h0000_0000_0123, 1'b1);
        // reads walk the oldest sequence across the wrap to zero
        send_item(MODE_READ, 16'hffff, 16'hffff, {SEQ_W{1'b1}}, 1'b1);
        send_item(MODE_READ, 16'h0000, 16'h0000, '0, 1'b0);
        // read that empties the ring, then an empty read
        send_item(MODE_READ, 16'h1234, 16'h5678, '0, 1'b0);
        send_item(MODE_READ, 16'h0000, 16'h0000, '0, 1'b0);
        // unused mode code on an empty ring
        send_item(MODE_UNUSED, 16'hffff, 16'hffff, {SEQ_W{1'b1}}, 1'b1);
        // sequence at the top value, read wraps it and empties the ring
        send_item(MODE_WRITE, 16'h0000, 16'hffff, {SEQ_W{1'b1}}, 1'b1);
        send_item(MODE_READ, 16'h0000, 16'h0000, '0, 1'b0);
        // clear of a non-empty ring, then empty read after clear
        send_item(MODE_WRITE, 16'h5555, 16'haaaa, 48'h8000_0000_0000, 1'b0);
        send_item(MODE_WRITE, 16'haaaa, 16'h5555, 48'h8000_0000_0001, 1'b1);
        send_item(MODE_CLEAR, 16'hffff, 16'hffff, {SEQ_W{1'b1}}, 1'b1);
        send_item(MODE_READ, 16'h0000, 16'h0000, '0, 1'b0);
        // write after clear takes its own sequence; unused code while holding
        send_item(MODE_WRITE, 16'h0001, 16'hfffe, 48'h0000_0000_0005, 1'b1);
        send_item(MODE_UNUSED, 16'h0000, 16'h0000, '0, 1'b0);
        send_item(MODE_READ, 16'h0000, 16'h0000, '0, 1'b1);
        send_item(MODE_CLEAR, 16'h0000, 16'h0000, '0, 1'b0);

        // ---------------- random part ----------------
        while (ring_items < RANDOM_ITEMS)
        begin
            if (ring_items >= NO_IDLE_AFTER)
                no_idle = 1'b1;
            // two overrun episodes; the first one is drained completely so
            // the read pointer comes back to zero from a wrapped position
            if (fills_done < 2 && ring_items >= fills_done * 400)
            begin
                overrun_fill();
                if (fills_done == 0)
                    read_burst(CAP + 3);
                fills_done++;
            end
            n = $urandom_range(1, 40);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: write_burst(n);
                4, 5, 6:    read_burst(n);
                7, 8:       noise_burst(n);
                default:
                begin
                    n = 1;
                    send_item(MODE_CLEAR, 16'($urandom), 16'($urandom), rand48(), 1'($urandom));
                end
            endcase
            ring_items += n;
        end
        item_valid <= 1'b0;

        // wait out every outstanding result, then settle to catch strays
        while (ring_sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (ring_sb.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
